[rtl/bvp_pkg.sv]
`default_nettype none

package bvp_pkg;

    // Voltage input width (13 to 16 bits); any voltage at or above 4200 mV reads as full charge
    localparam int VOLT_BITS = 13;

    localparam int CURVE_W   = 13;
    localparam int SEG_CNT   = 20;
    localparam int IDX_W     = 5;
    localparam int Q8_W      = 15;
    localparam int DIFF_W    = 10;   // hi - v, at most 339
    localparam int DEN_W     = 9;    // hi - lo, at most 340
    localparam int NUM_W     = 21;   // 1280 * (hi - v)
    localparam int QUO_W     = 11;   // quotient never exceeds 1280
    localparam int CNT_W     = 5;

    localparam logic [CURVE_W-1:0] FULL_MV  = 13'd4200;
    localparam logic [CURVE_W-1:0] EMPTY_MV = 13'd3270;
    localparam logic [Q8_W-1:0]    FULL_Q8  = 15'd25600;
    localparam logic [Q8_W-1:0]    ZERO_Q8  = 15'd0;
    localparam logic [QUO_W-1:0]   STEP_Q8  = 11'd1280;

    typedef logic [VOLT_BITS-1:0] t_mv;
    typedef logic [CURVE_W-1:0]   t_curve;
    typedef logic [Q8_W-1:0]      t_q8;

    // Upper and lower end of each segment, highest segment first
    localparam t_curve SEG_HI [SEG_CNT] = '{
        13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020,
        13'd3980, 13'd3950, 13'd3910, 13'd3870, 13'd3850,
        13'd3840, 13'd3820, 13'd3800, 13'd3790, 13'd3770,
        13'd3750, 13'd3730, 13'd3710, 13'd3690, 13'd3610
    };

    localparam t_curve SEG_LO [SEG_CNT] = '{
        13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980,
        13'd3950, 13'd3910, 13'd3870, 13'd3850, 13'd3840,
        13'd3820, 13'd3800, 13'd3790, 13'd3770, 13'd3750,
        13'd3730, 13'd3710, 13'd3690, 13'd3610, 13'd3270
    };

    // Charge at the top of each segment, Q8
    localparam t_q8 SEG_TOP [SEG_CNT] = '{
        15'd25600, 15'd24320, 15'd23040, 15'd21760, 15'd20480,
        15'd19200, 15'd17920, 15'd16640, 15'd15360, 15'd14080,
        15'd12800, 15'd11520, 15'd10240, 15'd8960,  15'd7680,
        15'd6400,  15'd5120,  15'd3840,  15'd2560,  15'd1280
    };

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] diff;
        logic [DEN_W-1:0]  den;
    } t_div_ctl;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } t_div_sts;

endpackage

`default_nettype wire

[rtl/bvp_div.sv]
`default_nettype none

// Bit-serial restoring divider: quo = (1280 * diff) / den, one bit a cycle.
module bvp_div
    import bvp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_ctl i_ctl,
    output t_div_sts      o_sts
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [NUM_W-1:0]  r_num,  n_num;
    logic [DEN_W-1:0]  r_rem,  n_rem;
    logic [DEN_W-1:0]  r_den,  n_den;
    logic [QUO_W-1:0]  r_quo,  n_quo;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_sub;
    logic              w_ge;
    logic [NUM_W-1:0]  w_scaled;

    always_comb begin
        // 1280 * x = (x << 10) + (x << 8)
        w_scaled = (NUM_W'(i_ctl.diff) << 10) + (NUM_W'(i_ctl.diff) << 8);
        w_trial  = {r_rem, r_num[NUM_W-1]};
        w_ge     = w_trial >= {1'b0, r_den};
        w_sub    = w_trial - {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;

        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_num  = w_scaled;
            n_rem  = '0;
            n_den  = i_ctl.den;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_rem = w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_sts.done = r_done;
    assign o_sts.quo  = r_quo;

endmodule

`default_nettype wire

[rtl/battery_voltage_to_percent_core.sv]
`default_nettype none

// Battery voltage to state of charge. Takes one word i_batt_mv (millivolts)
// and returns one word o_percent_q8 (percent times 256, 0 to 25600). At or
// above 4200 mV the result is 25600, at or below 3270 mV it is 0. Between
// those, a 20-segment curve is walked from the top one segment per cycle
// until the segment holding the voltage is found, and the drop below the
// segment top, 1280*(hi-v)/(hi-lo) truncated, comes from a bit-serial
// divider that retires one quotient bit per cycle. A saturated voltage
// goes straight to the hold state; otherwise the search state starts the
// divider on finding the segment, the divide state waits for the
// divider's done and takes the result, and the hold state loads it
// into the output register when that register is free. One word is in
// flight at a time; o_in_stall is high from accept until the result is
// loaded into the output register, which can then wait on i_out_stall
// while the next word is taken.
module battery_voltage_to_percent_core
    import bvp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_mv      i_batt_mv,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_q8           o_percent_q8
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_DIV    = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_mv              r_v,     n_v;
    logic [IDX_W-1:0] r_idx,   n_idx;
    t_q8              r_res,   n_res;
    logic             r_out_valid, n_out_valid;
    t_q8              r_out_q8,    n_out_q8;

    t_div_ctl         w_div_ctl;
    t_div_sts         w_div_sts;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_hit;
    t_mv              w_hi;
    t_mv              w_lo;

    // current segment ends, widened to the input width
    assign w_hi  = VOLT_BITS'(SEG_HI[r_idx]);
    assign w_lo  = VOLT_BITS'(SEG_LO[r_idx]);
    // search runs top-down, so v <= hi always holds here
    assign w_hit = (r_state == S_SEARCH) && (r_v >= w_lo);

    assign w_div_ctl.start = w_hit;
    assign w_div_ctl.diff  = DIFF_W'(w_hi - r_v);
    assign w_div_ctl.den   = DEN_W'(w_hi - w_lo);

    bvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_sts   (w_div_sts)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_q8    = r_out_q8;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_v   = i_batt_mv;
                    n_idx = '0;
                    if (i_batt_mv >= VOLT_BITS'(FULL_MV)) begin
                        n_res   = FULL_Q8;
                        n_state = S_HOLD;
                    end else if (i_batt_mv <= VOLT_BITS'(EMPTY_MV)) begin
                        n_res   = ZERO_Q8;
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_res   = SEG_TOP[r_idx] - Q8_W'(w_div_sts.quo);
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_q8    = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_v      <= n_v;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_out_q8 <= n_out_q8;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_percent_q8 = r_out_q8;

`ifndef ASSERT_OFF
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_percent_q8 <= FULL_Q8))
        else $error("result above full scale");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (w_div_sts.quo <= STEP_Q8))
        else $error("quotient exceeds one step");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide phase");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accept");
`endif

endmodule

`default_nettype wire
